// File: rtl/core/slcg_pkg.sv
// Shared constants for the shuffled LCG generator.
// No dependencies; imported by slcg_mulmod and the top level.
package slcg_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int SEED_STEPS  = TABLE_DEPTH + 8;
   localparam int CNT_W       = $clog2(SEED_STEPS);

   localparam int VAL_W  = 31;
   localparam int MULT_W = 15;
   localparam int PROD_W = VAL_W + MULT_W;

   localparam logic [MULT_W-1:0] LCG_MULT   = MULT_W'(16807);
   localparam logic [VAL_W-1:0]  LCG_MOD    = VAL_W'(31'h7FFF_FFFF);
   localparam logic [VAL_W-1:0]  SAMPLE_MAX = VAL_W'(2147483389);

   // Slot divisor 1 + (2^31-2)/depth is 2^(31-IDX_W) for a power-of-two depth.
   localparam int SLOT_SHIFT = VAL_W - IDX_W;

endpackage

// File: rtl/core/slcg_mulmod.sv
// Two-stage x * 16807 mod (2^31 - 1) unit shared by seeding and drawing.
// Depends on slcg_pkg.
module slcg_mulmod
   import slcg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VAL_W-1:0] operand,
   output logic             done,
   output logic [VAL_W-1:0] result
);

   logic [PROD_W-1:0] prod_ff;
   logic              prod_vld_ff;
   logic [VAL_W-1:0]  res_ff;
   logic              res_vld_ff;
   logic [VAL_W:0]    fold_sum;
   logic [VAL_W-1:0]  res_in;

   // 2^31 == 1 mod M, so fold the high part onto the low part
   always_comb begin
      fold_sum = {1'b0, prod_ff[VAL_W-1:0]}
               + {{(VAL_W + 1 - MULT_W){1'b0}}, prod_ff[PROD_W-1:VAL_W]};
      if (fold_sum >= {1'b0, LCG_MOD}) begin
         res_in = fold_sum[VAL_W-1:0] - LCG_MOD;
      end else begin
         res_in = fold_sum[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         res_vld_ff  <= 1'b0;
      end else begin
         prod_vld_ff <= start;
         res_vld_ff  <= prod_vld_ff;
      end
      prod_ff <= PROD_W'(operand) * PROD_W'(LCG_MULT);
      res_ff  <= res_in;
   end

   assign done   = res_vld_ff;
   assign result = res_ff;

endmodule

// File: rtl/core/shuffled_lcg_uniform_generator_unit.sv
// Shuffled multiplicative LCG with a 32-entry shuffle table; top level.
// Depends on slcg_pkg and slcg_mulmod.
// Flow: a draw goes from accept through S_DRAW_GO, S_DRAW_WAIT and S_RESP to
// rsp_valid; a reseed (or the first draw after reset) first runs 40 generator steps.
// Requests: a new request is taken only in S_IDLE, once the previous word is in the rsp
// register; the two-stage mulmod unit is shared, and a held rsp word stalls the next one.
// Reset: generator value 1, not seeded; table contents undefined until seeded.
module shuffled_lcg_uniform_generator_unit
   import slcg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_action,
   input  logic [VAL_W-1:0] req_seed_value,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [VAL_W-1:0] rsp_sample
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEED_GO,
      S_SEED_WAIT,
      S_DRAW_GO,
      S_DRAW_WAIT,
      S_RESP
   } state_type;

   state_type         state_ff;
   logic [VAL_W-1:0]  lcg_ff;
   logic [VAL_W-1:0]  shuf_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [IDX_W-1:0]  slot_ff;
   logic [VAL_W-1:0]  rd_ff;
   logic              rsp_valid_ff;
   logic [VAL_W-1:0]  rsp_sample_ff;

   logic [VAL_W-1:0]  table_mem [TABLE_DEPTH];

   logic              unit_start;
   logic              unit_done;
   logic [VAL_W-1:0]  unit_result;
   logic              accept;
   logic              need_seed;
   logic [VAL_W-1:0]  seed_raw;
   logic [VAL_W-1:0]  seed_in;
   logic [IDX_W-1:0]  slot_in;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic              out_free;

   slcg_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (unit_start),
      .operand (lcg_ff),
      .done    (unit_done),
      .result  (unit_result)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign unit_start = (state_ff == S_SEED_GO) || (state_ff == S_DRAW_GO);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      need_seed = req_action || (shuf_ff == '0);
      seed_raw  = req_action ? req_seed_value : VAL_W'(1);
      // zero and the modulus itself are both the zero residue
      if (seed_raw == '0 || seed_raw == LCG_MOD) begin
         seed_in = VAL_W'(1);
      end else begin
         seed_in = seed_raw;
      end
      slot_in = shuf_ff[VAL_W-1:SLOT_SHIFT];
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot_ff;
      if (state_ff == S_SEED_WAIT && unit_done && cnt_ff < CNT_W'(TABLE_DEPTH)) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff[IDX_W-1:0];
      end else if (state_ff == S_DRAW_WAIT && unit_done) begin
         wr_en   = 1'b1;
         wr_addr = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= unit_result;
      end
      if (state_ff == S_DRAW_GO) begin
         rd_ff <= table_mem[slot_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lcg_ff       <= VAL_W'(1);
         shuf_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in S_RESP the output register is reloaded below
         if (rsp_valid_ff && rsp_ready && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (need_seed) begin
                     lcg_ff   <= seed_in;
                     cnt_ff   <= CNT_W'(SEED_STEPS - 1);
                     state_ff <= S_SEED_GO;
                  end else begin
                     state_ff <= S_DRAW_GO;
                  end
               end
            end
            S_SEED_GO: begin
               state_ff <= S_SEED_WAIT;
            end
            S_SEED_WAIT: begin
               if (unit_done) begin
                  lcg_ff <= unit_result;
                  if (cnt_ff == '0) begin
                     // slot 0 was just filled; it also seeds the shuffled output
                     shuf_ff  <= unit_result;
                     state_ff <= S_DRAW_GO;
                  end else begin
                     cnt_ff   <= cnt_ff - CNT_W'(1);
                     state_ff <= S_SEED_GO;
                  end
               end
            end
            S_DRAW_GO: begin
               slot_ff  <= slot_in;
               state_ff <= S_DRAW_WAIT;
            end
            S_DRAW_WAIT: begin
               if (unit_done) begin
                  lcg_ff   <= unit_result;
                  shuf_ff  <= rd_ff;
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_sample_ff <= (shuf_ff > SAMPLE_MAX) ? SAMPLE_MAX : shuf_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

// File: bench/testbench.sv
// Testbench for shuffled_lcg_uniform_generator_unit: directed and random draw/reseed traffic.
// Checks each rsp word against a local generator-and-shuffle-table predictor.
// Depends on slcg_pkg for VAL_W and TABLE_DEPTH.
module testbench;
   import slcg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [VAL_W-1:0] val_type;

   localparam longint unsigned GEN_MULT    = 16807;
   localparam longint unsigned GEN_MODULUS = 2147483647;
   localparam longint unsigned SLOT_DIV    = 1 + (GEN_MODULUS - 1) / TABLE_DEPTH;
   localparam longint unsigned SAT_LIMIT   = 2147483389;
   localparam int              WARMUP      = TABLE_DEPTH + 8;
   localparam int              CYCLE_LIMIT = 2_000_000;
   localparam int              DRAIN_WAIT  = 150;
   localparam bit              ACT_DRAW    = 1'b0;
   localparam bit              ACT_RESEED  = 1'b1;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   logic    req_action;
   val_type req_seed_value;
   logic    rsp_valid;
   logic    rsp_ready;
   val_type rsp_sample;

   shuffled_lcg_uniform_generator_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_seed_value (req_seed_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample     (rsp_sample)
   );

   // predictor state, as after reset: generator 1, not seeded
   val_type gen_state     = val_type'(1);
   val_type last_shuffled = '0;
   val_type shuffle_slots [TABLE_DEPTH];

   val_type pending_samples [$];
   int      mismatch_count  = 0;
   bit      idle_enabled    = 1'b1;
   int      hold_off_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic val_type mod_mul(val_type a, val_type b);
      longint unsigned prod;
      prod = longint'(a) * longint'(b);
      return val_type'(prod % GEN_MODULUS);
   endfunction

   function automatic val_type mod_pow(val_type base, longint unsigned ex);
      val_type acc;
      val_type sq;
      acc = 1;
      sq  = base;
      while (ex != 0) begin
         if (ex[0])
            acc = mod_mul(acc, sq);
         sq = mod_mul(sq, sq);
         ex = ex >> 1;
      end
      return acc;
   endfunction

   function automatic void load_seed(val_type seed);
      val_type s;
      s = seed;
      if (s == 0 || longint'(s) >= GEN_MODULUS)
         s = 1;
      gen_state = s;
      for (int j = WARMUP - 1; j >= 0; j--) begin
         gen_state = mod_mul(gen_state, val_type'(GEN_MULT));
         if (j < TABLE_DEPTH)
            shuffle_slots[j] = gen_state;
      end
      last_shuffled = shuffle_slots[0];
   endfunction

   function automatic val_type predict_sample(bit action, val_type seed);
      longint unsigned slot;
      if (action == ACT_RESEED)
         load_seed(seed);
      else if (last_shuffled == 0)
         load_seed(1);
      gen_state = mod_mul(gen_state, val_type'(GEN_MULT));
      slot = longint'(last_shuffled) / SLOT_DIV;
      if (slot >= TABLE_DEPTH)
         slot = TABLE_DEPTH - 1;
      last_shuffled       = shuffle_slots[slot];
      shuffle_slots[slot] = gen_state;
      return (longint'(last_shuffled) > SAT_LIMIT) ? val_type'(SAT_LIMIT) : last_shuffled;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 80);
   endfunction

   task automatic send_word(bit action, val_type seed);
      int gap;
      req_valid      <= 1'b1;
      req_action     <= action;
      req_seed_value <= seed;
      do
         @(posedge clock);
      while (req_ready !== 1'b1);
      pending_samples.push_back(predict_sample(action, seed));
      gap = 0;
      if (idle_enabled && $urandom_range(0, 99) < 40)
         gap = idle_len();
      if (gap > 0) begin
         req_valid      <= 1'b0;
         req_action     <= 1'($urandom());
         req_seed_value <= val_type'($urandom());
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0)
         @(posedge clock);
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            stall_left      = hold_off_cycles;
            hold_off_cycles = 0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (!idle_enabled || $urandom_range(0, 99) < 60) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready  <= 1'b0;
            stall_left = idle_len() - 1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      val_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_samples.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual sample %0d",
                     $time, rsp_sample);
            mismatch_count++;
         end else begin
            want = pending_samples.pop_front();
            if (rsp_sample !== want) begin
               $display("%0t: sample mismatch, expected %0d, actual %0d",
                        $time, want, rsp_sample);
               mismatch_count++;
            end
         end
      end
   end

   // draws right after reset seed from 1 whatever seed_value holds
   task automatic test_draw_before_seed();
      send_word(ACT_DRAW, val_type'(12345));
      send_word(ACT_DRAW, '1);
      send_word(ACT_DRAW, '0);
   endtask

   task automatic test_seed_extremes();
      val_type seeds [6];
      seeds = '{val_type'(0), val_type'(1), val_type'(GEN_MODULUS - 1),
                val_type'(GEN_MODULUS), val_type'(31'h2AAA_AAAA), val_type'(31'h5555_5555)};
      foreach (seeds[i]) begin
         send_word(ACT_RESEED, seeds[i]);
         send_word(ACT_DRAW, ~seeds[i]);
      end
   endtask

   // Pick seeds whose first draw lands on a table value above the clamp:
   // slot s holds seed*M^(40-s), slot 0 holds seed*M^40, and slot 0 selects s.
   task automatic test_saturation();
      val_type inv_mult;
      val_type seed;
      val_type head;
      val_type hits [$];
      inv_mult = mod_pow(val_type'(GEN_MULT), GEN_MODULUS - 2);
      for (longint unsigned target = GEN_MODULUS - 1;
           target > SAT_LIMIT && hits.size() < 2; target--) begin
         for (int s = 0; s < TABLE_DEPTH && hits.size() < 2; s++) begin
            head = mod_mul(val_type'(target), mod_pow(val_type'(GEN_MULT), s));
            if (longint'(head) / SLOT_DIV == s) begin
               seed = mod_mul(val_type'(target), mod_pow(inv_mult, WARMUP - s));
               hits.push_back(seed);
            end
         end
      end
      foreach (hits[i]) begin
         send_word(ACT_RESEED, hits[i]);
         send_word(ACT_DRAW, val_type'($urandom()));
      end
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_backpressure();
      idle_enabled    = 1'b0;
      hold_off_cycles = 300;
      for (int i = 0; i < 20; i++)
         send_word((i == 7) ? ACT_RESEED : ACT_DRAW, val_type'($urandom()));
      idle_enabled = 1'b1;
   endtask

   task automatic test_pause_until_drained();
      wait_drained();
      for (int i = 0; i < 5; i++)
         send_word(ACT_DRAW, val_type'($urandom()));
   endtask

   task automatic test_random_traffic(int count);
      bit      action;
      val_type seed;
      for (int i = 0; i < count; i++) begin
         idle_enabled = !(i >= 300 && i < 400);
         action = ($urandom_range(0, 9) == 0) ? ACT_RESEED : ACT_DRAW;
         seed   = val_type'($urandom());
         if (action == ACT_RESEED && $urandom_range(0, 7) == 0)
            seed = $urandom_range(0, 1) ? val_type'(0) : val_type'(GEN_MODULUS);
         send_word(action, seed);
      end
      idle_enabled = 1'b1;
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_action     <= 1'b0;
      req_seed_value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_draw_before_seed();
      test_seed_extremes();
      test_saturation();
      test_backpressure();
      test_pause_until_drained();
      test_random_traffic(660);

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
